[hw/rtl/data_directive_byte_parser_defines.svh]
// Assertion helpers used by the parser top module.
`ifndef DATA_DIRECTIVE_BYTE_PARSER_DEFINES_SVH
`define DATA_DIRECTIVE_BYTE_PARSER_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define DDBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("parser assertion failed");

// Next-cycle implication, checked while out of reset.
`define DDBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("parser assertion failed");

// Next-cycle implication that also holds across reset.
`define DDBP_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("parser assertion failed");

`endif

[hw/rtl/ddbp_pkg.sv]
package ddbp_pkg;

    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 63;
    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    typedef struct packed {
        logic [BYTE_W-1:0] character;
        logic              end_of_line;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              from_number;
    } t_result;

    typedef struct packed {
        logic skip_mode;
        logic value_zero;
    } t_core_status;

endpackage

[hw/rtl/data_directive_byte_parser.sv]
// Data directive byte parser: takes one character of a data-directive line per transfer
// (or an end-of-line mark; a zero character also ends the line) and gives the data bytes
// it stands for, from quoted strings with backslash escapes and from decimal or 0x-prefixed
// hex numbers (low byte of a value that saturates at 2^63-1). It takes one character every
// cycle while the output side does not stall; a character passes the input register, then
// the combinational mode step and radix multiply-add in the core, then the result register.
// Characters that cause no byte give no output transfer.
`include "data_directive_byte_parser_defines.svh"

module data_directive_byte_parser
    import ddbp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [BYTE_W-1:0] i_character,
    input  logic              i_end_of_line,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_data_byte,
    output logic              o_from_number
);

    logic         item_valid;
    t_item        item;
    logic         take;
    logic         out_ready;
    logic         res_valid;
    t_result      result;
    t_core_status status;
    logic         load;

    assign load = res_valid && take;

    ddbp_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_character   (i_character),
        .i_end_of_line (i_end_of_line),
        .i_take        (take),
        .o_valid       (item_valid),
        .o_item        (item)
    );

    ddbp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (item_valid),
        .i_item      (item),
        .i_ready     (out_ready),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_result    (result),
        .o_status    (status)
    );

    ddbp_out_reg u_out_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_result      (result),
        .o_ready       (out_ready),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_data_byte   (o_data_byte),
        .o_from_number (o_from_number)
    );

    // A line end returns the parser to its reset state.
    `DDBP_ASSERT_NEXT(a_eol_resets_state, i_clk, i_rst_n, take && item.end_of_line, status.skip_mode && status.value_zero)
    // A held result with a full input register must back-pressure the input side.
    `DDBP_ASSERT_NOW(a_full_pipe_stalls, i_clk, i_rst_n, o_valid && i_stall && item_valid, o_stall && !take)
    // Reset leaves no result pending.
    `DDBP_ASSERT_ALWAYS_NEXT(a_reset_clears_out, i_clk, !i_rst_n, !o_valid && !o_stall)

endmodule

[hw/rtl/ddbp_in_reg.sv]
module ddbp_in_reg
    import ddbp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [BYTE_W-1:0]   i_character,
    input  logic                i_end_of_line,
    input  logic                i_take,
    output logic                o_valid,
    output t_item               o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  accept;

    // The register is free when empty or when the core consumes it this cycle.
    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.character   <= i_character;
            r_item.end_of_line <= i_end_of_line;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[hw/rtl/ddbp_core.sv]
module ddbp_core
    import ddbp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  t_item        i_item,
    input  logic         i_ready,
    output logic         o_take,
    output logic         o_res_valid,
    output t_result      o_result,
    output t_core_status o_status
);

    typedef enum logic [5:0] {
        MODE_SKIP = 6'b000001,
        MODE_STR  = 6'b000010,
        MODE_ESC  = 6'b000100,
        MODE_ZERO = 6'b001000,
        MODE_DEC  = 6'b010000,
        MODE_HEX  = 6'b100000
    } t_mode;

    localparam logic [BYTE_W-1:0] CHAR_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CHAR_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_X_LO   = 8'h78;
    localparam logic [BYTE_W-1:0] CHAR_X_UP   = 8'h58;
    localparam logic [BYTE_W-1:0] CHAR_N      = 8'h6E;
    localparam logic [BYTE_W-1:0] CHAR_T      = 8'h74;
    localparam logic [BYTE_W-1:0] CHAR_R      = 8'h72;
    localparam logic [BYTE_W-1:0] BYTE_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] BYTE_CR     = 8'h0D;
    localparam int PROD_W = VALUE_W + 4;

    function automatic logic is_dec(input logic [BYTE_W-1:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    // Returns {valid, digit value}.
    function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] t;
        t = 8'h00;
        if (c inside {[8'h30:8'h39]}) begin
            return {1'b1, c[3:0]};
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            t = {5'b0, c[2:0]} + 8'd9;
            return {1'b1, t[3:0]};
        end
        return 5'b0;
    endfunction

    function automatic logic [BYTE_W-1:0] escape_map(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] m;
        case (c)
            CHAR_N:    m = BYTE_LF;
            CHAR_T:    m = BYTE_TAB;
            CHAR_R:    m = BYTE_CR;
            CHAR_ZERO: m = CHAR_NUL;
            default:   m = c;
        endcase
        return m;
    endfunction

    t_mode              r_mode;
    t_mode              n_mode;
    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] n_value;

    logic [BYTE_W-1:0]  c;
    logic               eol;
    logic               in_number;
    logic [4:0]         hex_d;
    logic [3:0]         digit;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  sum;
    logic [VALUE_W-1:0] acc;
    t_mode              sk_mode;
    logic               sk_load;
    logic [VALUE_W-1:0] sk_value;
    logic               end_num;

    assign o_take    = i_valid && i_ready;
    assign c         = i_item.character;
    assign eol       = i_item.end_of_line || (c == CHAR_NUL);
    assign in_number = (r_mode == MODE_ZERO) || (r_mode == MODE_DEC) || (r_mode == MODE_HEX);

    // Multiply-add by the radix with saturation: shifts and at most two adds, then a range check.
    assign hex_d = hex_digit(c);
    assign digit = (r_mode == MODE_HEX) ? hex_d[3:0] : c[3:0];
    assign prod  = (r_mode == MODE_HEX) ? {r_value, 4'b0}
                 : ({1'b0, r_value, 3'b0} + {3'b0, r_value, 1'b0});
    assign sum   = prod + {{(PROD_W-4){1'b0}}, digit};
    assign acc   = (|sum[PROD_W-1:VALUE_W]) ? VALUE_MAX : sum[VALUE_W-1:0];

    // What a character does when no number or string is open.
    always_comb begin
        sk_mode  = MODE_SKIP;
        sk_load  = 1'b0;
        sk_value = {{(VALUE_W-4){1'b0}}, c[3:0]};
        if (c == CHAR_QUOTE) begin
            sk_mode = MODE_STR;
        end else if (c == CHAR_ZERO) begin
            sk_mode = MODE_ZERO;
            sk_load = 1'b1;
        end else if (is_dec(c)) begin
            sk_mode = MODE_DEC;
            sk_load = 1'b1;
        end
    end

    always_comb begin
        n_mode      = r_mode;
        n_value     = r_value;
        o_res_valid = 1'b0;
        o_result    = '{data_byte: r_value[BYTE_W-1:0], from_number: 1'b1};
        end_num     = 1'b0;
        if (o_take) begin
            if (eol) begin
                o_res_valid = in_number;
                n_mode      = MODE_SKIP;
                n_value     = '0;
            end else begin
                case (r_mode)
                    MODE_STR: begin
                        if (c == CHAR_QUOTE) begin
                            n_mode = MODE_SKIP;
                        end else if (c == CHAR_BSLASH) begin
                            n_mode = MODE_ESC;
                        end else begin
                            o_res_valid = 1'b1;
                            o_result    = '{data_byte: c, from_number: 1'b0};
                        end
                    end
                    MODE_ESC: begin
                        n_mode      = MODE_STR;
                        o_res_valid = 1'b1;
                        o_result    = '{data_byte: escape_map(c), from_number: 1'b0};
                    end
                    MODE_ZERO: begin
                        if (c == CHAR_X_LO || c == CHAR_X_UP) begin
                            n_mode = MODE_HEX;
                        end else if (is_dec(c)) begin
                            n_mode  = MODE_DEC;
                            n_value = acc;
                        end else begin
                            end_num = 1'b1;
                        end
                    end
                    MODE_DEC: begin
                        if (is_dec(c)) begin
                            n_value = acc;
                        end else begin
                            end_num = 1'b1;
                        end
                    end
                    MODE_HEX: begin
                        if (hex_d[4]) begin
                            n_value = acc;
                        end else begin
                            end_num = 1'b1;
                        end
                    end
                    default: begin
                        n_mode = sk_mode;
                        if (sk_load) begin
                            n_value = sk_value;
                        end
                    end
                endcase
                // The terminating character is then handled as in skip mode.
                if (end_num) begin
                    o_res_valid = 1'b1;
                    n_mode      = sk_mode;
                    n_value     = sk_load ? sk_value : '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_SKIP;
            r_value <= '0;
        end else begin
            r_mode  <= n_mode;
            r_value <= n_value;
        end
    end

    assign o_status.skip_mode  = (r_mode == MODE_SKIP);
    assign o_status.value_zero = (r_value == '0);

endmodule

[hw/rtl/ddbp_out_reg.sv]
module ddbp_out_reg
    import ddbp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_result           i_result,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_data_byte,
    output logic              o_from_number
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;
    logic    transfer;

    assign transfer = r_valid && !i_stall;
    assign o_ready  = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (transfer) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid       = r_valid;
    assign o_data_byte   = r_result.data_byte;
    assign o_from_number = r_result.from_number;

endmodule

[dv/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ddbp_pkg::*;

    typedef enum logic [2:0] {
        PM_SKIP      = 3'd0,
        PM_STRING    = 3'd1,
        PM_ESCAPE    = 3'd2,
        PM_LEAD_ZERO = 3'd3,
        PM_DECIMAL   = 3'd4,
        PM_HEX       = 3'd5
    } t_parse_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
        logic [4:0] reps;
        logic       check;
        t_result    want;
    } t_stim_row;

    localparam logic [7:0]  QUOTE  = 8'h22;
    localparam logic [7:0]  BSLASH = 8'h5C;
    localparam logic [7:0]  COMMA  = 8'h2C;
    localparam logic [7:0]  SPACE  = 8'h20;
    localparam logic [7:0]  TAB    = 8'h09;
    localparam logic [63:0] SAT_VALUE = {1'b0, VALUE_MAX};
    localparam t_result     NO_BYTE = '0;
    localparam logic [5:0][7:0] ESC_CHARS = {"n", "t", "r", BSLASH, QUOTE, "0"};
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_CHARS = 420;
    localparam int MAX_PRINTED = 50;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [BYTE_W-1:0] i_character = '0;
    logic              i_end_of_line = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [BYTE_W-1:0] o_data_byte;
    logic              o_from_number;

    // Literal expectation that travels with the character in the directed part.
    logic    lit_check = 1'b0;
    t_result lit_want = '0;

    int idle_pct = 0;
    int stall_pct = 0;

    t_parse_mode pm_mode = PM_SKIP;
    logic [63:0] pm_value = '0;
    t_result     expected_bytes[$];

    int chars_sent = 0;
    int chars_used = 0;
    int string_bytes = 0;
    int number_bytes = 0;
    int saturated_digits = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    t_stim_row directed_rows [26] = '{
        '{"A",    1'b1, 5'd1,  1'b0, NO_BYTE},
        '{QUOTE,  1'b0, 5'd1,  1'b0, NO_BYTE},
        '{8'hFF,  1'b0, 5'd1,  1'b1, '{8'hFF, 1'b0}},
        '{BSLASH, 1'b0, 5'd1,  1'b0, NO_BYTE},
        '{"n",    1'b0, 5'd1,  1'b1, '{8'h0A, 1'b0}},
        '{BSLASH, 1'b0, 5'd1,  1'b0, NO_BYTE},
        '{QUOTE,  1'b0, 5'd1,  1'b1, '{8'h22, 1'b0}},
        '{BSLASH, 1'b0, 5'd1,  1'b0, NO_BYTE},
        '{8'hC8,  1'b0, 5'd1,  1'b1, '{8'hC8, 1'b0}},
        '{QUOTE,  1'b0, 5'd1,  1'b0, NO_BYTE},
        '{8'h80,  1'b0, 5'd1,  1'b0, NO_BYTE},
        '{"0",    1'b0, 5'd1,  1'b0, NO_BYTE},
        '{"X",    1'b0, 5'd1,  1'b0, NO_BYTE},
        '{"F",    1'b0, 5'd17, 1'b0, NO_BYTE},
        '{COMMA,  1'b0, 5'd1,  1'b1, '{8'hFF, 1'b1}},
        '{"0",    1'b0, 5'd1,  1'b0, NO_BYTE},
        '{"x",    1'b0, 5'd1,  1'b0, NO_BYTE},
        '{"g",    1'b0, 5'd1,  1'b1, '{8'h00, 1'b1}},
        '{"2",    1'b0, 5'd1,  1'b0, NO_BYTE},
        '{"5",    1'b0, 5'd1,  1'b0, NO_BYTE},
        '{QUOTE,  1'b0, 5'd1,  1'b1, '{8'h19, 1'b1}},
        '{"A",    1'b0, 5'd1,  1'b0, NO_BYTE},
        '{BSLASH, 1'b0, 5'd1,  1'b0, NO_BYTE},
        '{8'h00,  1'b0, 5'd1,  1'b0, NO_BYTE},
        '{"7",    1'b0, 5'd1,  1'b0, NO_BYTE},
        '{"x",    1'b1, 5'd1,  1'b1, '{8'h07, 1'b1}}
    };

    data_directive_byte_parser DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_character   (i_character),
        .i_end_of_line (i_end_of_line),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_data_byte   (o_data_byte),
        .o_from_number (o_from_number)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit is_digit(input logic [7:0] ch);
        return ch >= "0" && ch <= "9";
    endfunction

    function automatic int hex_value(input logic [7:0] ch);
        if (is_digit(ch)) return ch - "0";
        if (ch >= "a" && ch <= "f") return ch - "a" + 10;
        if (ch >= "A" && ch <= "F") return ch - "A" + 10;
        return -1;
    endfunction

    // The value sticks at the largest positive 64-bit signed value.
    function automatic void add_digit(input logic [63:0] radix, input logic [63:0] digit);
        if (pm_value > (SAT_VALUE - digit) / radix) begin
            pm_value = SAT_VALUE;
            saturated_digits++;
        end else begin
            pm_value = pm_value * radix + digit;
        end
    endfunction

    function automatic void start_token(input logic [7:0] ch);
        if (ch == QUOTE) begin
            pm_mode = PM_STRING;
        end else if (ch == "0") begin
            pm_value = '0;
            pm_mode = PM_LEAD_ZERO;
        end else if (is_digit(ch)) begin
            pm_value = 64'(ch - "0");
            pm_mode = PM_DECIMAL;
        end else begin
            pm_mode = PM_SKIP;
        end
    endfunction

    function automatic bit parse_char(input logic [7:0] ch, input logic eol_in,
                                      output t_result res);
        bit number_open;
        int digit;
        res = NO_BYTE;
        number_open = pm_mode == PM_LEAD_ZERO || pm_mode == PM_DECIMAL || pm_mode == PM_HEX;
        if (eol_in || ch == 8'h00) begin
            res = '{pm_value[7:0], 1'b1};
            pm_mode = PM_SKIP;
            pm_value = '0;
            return number_open;
        end
        case (pm_mode)
            PM_STRING: begin
                if (ch == QUOTE) begin
                    pm_mode = PM_SKIP;
                    return 0;
                end
                if (ch == BSLASH) begin
                    pm_mode = PM_ESCAPE;
                    return 0;
                end
                res = '{ch, 1'b0};
                return 1;
            end
            PM_ESCAPE: begin
                pm_mode = PM_STRING;
                case (ch)
                    "n":     res = '{8'h0A, 1'b0};
                    "t":     res = '{8'h09, 1'b0};
                    "r":     res = '{8'h0D, 1'b0};
                    "0":     res = '{8'h00, 1'b0};
                    default: res = '{ch, 1'b0};
                endcase
                return 1;
            end
            PM_LEAD_ZERO: begin
                if (ch == "x" || ch == "X") begin
                    pm_mode = PM_HEX;
                    return 0;
                end
                if (is_digit(ch)) begin
                    add_digit(64'd10, 64'(ch - "0"));
                    pm_mode = PM_DECIMAL;
                    return 0;
                end
            end
            PM_DECIMAL: begin
                if (is_digit(ch)) begin
                    add_digit(64'd10, 64'(ch - "0"));
                    return 0;
                end
            end
            PM_HEX: begin
                digit = hex_value(ch);
                if (digit >= 0) begin
                    add_digit(64'd16, 64'(digit));
                    return 0;
                end
            end
            default: begin
                // Separators and unknown characters fall through to skip mode here.
                start_token(ch);
                return 0;
            end
        endcase
        // The number ends here and the character that ended it starts over.
        res = '{pm_value[7:0], 1'b1};
        pm_value = '0;
        start_token(ch);
        return 1;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic send_char(input logic [7:0] ch, input logic eol = 1'b0,
                             input logic check = 1'b0, input t_result want = NO_BYTE);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_character <= ch;
        i_end_of_line <= eol;
        lit_check <= check;
        lit_want <= want;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_bytes.size() != 0) @(posedge i_clk);
    endtask

    // One directive line: numbers, strings and noise with optional separators.
    task automatic send_line();
        int count;
        int kind;
        int v;
        logic [7:0] ch;
        repeat ($urandom_range(6, 1)) begin
            kind = $urandom_range(99);
            if (kind < 30) begin
                count = ($urandom_range(9) == 0) ? $urandom_range(22, 18) : $urandom_range(3, 1);
                repeat (count) send_char(8'("0" + $urandom_range(9)));
            end else if (kind < 55) begin
                send_char("0");
                send_char($urandom_range(1) ? "x" : "X");
                count = ($urandom_range(9) == 0) ? $urandom_range(18, 15) : $urandom_range(4, 0);
                repeat (count) begin
                    v = $urandom_range(15);
                    send_char(8'(v < 10 ? "0" + v : ($urandom_range(1) ? "a" : "A") + v - 10));
                end
            end else if (kind < 85) begin
                send_char(QUOTE);
                repeat ($urandom_range(6)) begin
                    if ($urandom_range(4) == 0) begin
                        send_char(BSLASH);
                        v = $urandom_range(7);
                        send_char(v < 6 ? ESC_CHARS[v] : 8'($urandom_range(255, 1)));
                    end else begin
                        do ch = 8'($urandom_range(255, 1)); while (ch == QUOTE || ch == BSLASH);
                        send_char(ch);
                    end
                end
                // Now and then the string is left open at the end of the line.
                if ($urandom_range(9) != 0) send_char(QUOTE);
            end else begin
                repeat ($urandom_range(3, 1)) send_char(8'($urandom_range(255, 1)));
            end
            case ($urandom_range(3))
                0: send_char(SPACE);
                1: send_char(COMMA);
                2: send_char(TAB);
                default: ;
            endcase
        end
        if ($urandom_range(1)) send_char(8'($urandom_range(255)), 1'b1);
        else send_char(8'h00);
        if ($urandom_range(24) == 0) wait_drained();
    endtask

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin : scoreboard
        t_result predicted;
        t_result wanted;
        t_parse_mode mode_was;
        bit produced;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                mode_was = pm_mode;
                produced = parse_char(i_character, i_end_of_line, predicted);
                if (lit_check) begin
                    produced = 1;
                    predicted = lit_want;
                end
                if (produced) expected_bytes.push_back(predicted);
                chars_sent++;
                if (mode_was != PM_SKIP || pm_mode != PM_SKIP || produced) chars_used++;
            end
            if (o_valid && !i_stall) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("byte %02h (from_number %0b) with none expected",
                                              o_data_byte, o_from_number));
                end else begin
                    wanted = expected_bytes.pop_front();
                    if (o_data_byte !== wanted.data_byte)
                        report_mismatch($sformatf("data_byte %02h, expected %02h",
                                                  o_data_byte, wanted.data_byte));
                    if (o_from_number !== wanted.from_number)
                        report_mismatch($sformatf("from_number %0b, expected %0b",
                                                  o_from_number, wanted.from_number));
                    if (wanted.from_number) number_bytes++;
                    else string_bytes++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("data_directive_byte_parser regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int start_count;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            repeat (directed_rows[r].reps)
                send_char(directed_rows[r].ch, directed_rows[r].eol,
                          directed_rows[r].check, directed_rows[r].want);

        for (int phase = 0; phase < 4; phase++) begin
            // Every phase change holds the sender until the output side is empty.
            wait_drained();
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 76; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 76; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            start_count = chars_sent;
            while (chars_sent - start_count < PHASE_CHARS) send_line();
        end

        wait_drained();
        stall_pct = 0;
        repeat (20) @(posedge i_clk);
        if (expected_bytes.size() != 0)
            report_mismatch($sformatf("%0d expected bytes never came out",
                                      expected_bytes.size()));

        $display("Parsed %0d characters (%0d outside plain skipping) over four idle/stall mixes.",
                 chars_sent, chars_used);
        $display("Checked %0d string bytes and %0d number bytes, %0d saturating digits, %0d errors.",
                 string_bytes, number_bytes, saturated_digits, mismatches);
        if (mismatches == 0) begin
            $display("data_directive_byte_parser regression: pass");
        end else begin
            $display("data_directive_byte_parser regression: fail");
        end
        $finish;
    end

endmodule
